@@ rtl/rbd_pkg.sv @@
// rbd_pkg: shared constants and types for the ring buffer deque
// no dependencies; used by rbd_ctrl, rbd_dpath and ring_buffer_deque_top
`timescale 1ns / 1ps

package rbd_pkg;

  // storage geometry
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_BACK  = 3'd4,
    KIND_READ_INDEX = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the request fields
    logic exec;     // run the operation against the store
    logic respond;  // result is on the output ports
  } cmd_t;

endpackage

@@ rtl/ring_buffer_deque_top.sv @@
// ring_buffer_deque_top: double-ended queue over a 1024-word circular store
// depends on rbd_pkg, rbd_ctrl and rbd_dpath
`timescale 1ns / 1ps

// Usage:
//   A request (kind_i, value_i, position_i) is taken at a rising edge where
//   start is high and busy is low. Kinds: push front, push back, pop front,
//   pop back, peek back, read at a logical index from the front.
//   Exactly one result per transaction: done_o is high for one cycle with
//   data_o, status_o (ok, full, empty, out of range) and count_o, the number
//   of entries held after the operation. data_o is zero unless a word was
//   popped, peeked or read.
//   The result strobe comes in the respond state, entered from the execute
//   state. A new request is not taken until the result has been shown: busy
//   covers the execute cycle (pointer update plus one slot memory access) and
//   the result cycle, since the memory read data is registered.
//   The receiver cannot stall: each result is shown for one cycle only.
//   Reset: head, tail and fill count clear to zero and the block is idle;
//   the slot memory is not cleared, only entries that were written are read.

module ring_buffer_deque_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rbd_pkg::KIND_W-1:0]   kind_i,
  input  logic [rbd_pkg::DATA_W-1:0]   value_i,
  input  logic [rbd_pkg::PTR_W-1:0]    position_i,
  output logic                         done_o,
  output logic [rbd_pkg::DATA_W-1:0]   data_o,
  output logic [rbd_pkg::STAT_W-1:0]   status_o,
  output logic [rbd_pkg::CNT_W-1:0]    count_o
);

  rbd_pkg::cmd_t cmd;

  // sequencing
  rbd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // storage and pointers
  rbd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .position_i (position_i),
    .data_o     (data_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  assign done_o = cmd.respond;

endmodule

@@ rtl/rbd_ctrl.sv @@
// rbd_ctrl: sequencing state machine for the ring buffer deque
// depends on rbd_pkg (cmd_t)
`timescale 1ns / 1ps

module rbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output rbd_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  assign busy          = (state_q != ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && start;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.respond = (state_q == ST_RESP);

endmodule

@@ rtl/rbd_dpath.sv @@
// rbd_dpath: pointers, fill count, slot memory and result registers
// depends on rbd_pkg (constants, kind_e, status_e, cmd_t)
`timescale 1ns / 1ps

module rbd_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbd_pkg::cmd_t                cmd_i,
  input  logic [rbd_pkg::KIND_W-1:0]   kind_i,
  input  logic [rbd_pkg::DATA_W-1:0]   value_i,
  input  logic [rbd_pkg::PTR_W-1:0]    position_i,
  output logic [rbd_pkg::DATA_W-1:0]   data_o,
  output logic [rbd_pkg::STAT_W-1:0]   status_o,
  output logic [rbd_pkg::CNT_W-1:0]    count_o
);

  localparam logic [rbd_pkg::PTR_W-1:0] PtrLast  = rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1);
  localparam logic [rbd_pkg::CNT_W-1:0] CntFull  = rbd_pkg::CNT_W'(rbd_pkg::DEPTH);
  localparam logic [rbd_pkg::PTR_W-1:0] PtrOne   = rbd_pkg::PTR_W'(1);
  localparam logic [rbd_pkg::CNT_W-1:0] CntOne   = rbd_pkg::CNT_W'(1);

  // captured request
  logic [rbd_pkg::KIND_W-1:0] kind_q;
  logic [rbd_pkg::DATA_W-1:0] value_q;
  logic [rbd_pkg::PTR_W-1:0]  pos_q;

  // deque state
  logic [rbd_pkg::PTR_W-1:0] head_q, head_d;
  logic [rbd_pkg::PTR_W-1:0] tail_q, tail_d;
  logic [rbd_pkg::CNT_W-1:0] fill_q, fill_d;

  // result registers
  logic [rbd_pkg::STAT_W-1:0] status_q, status_d;
  logic                       hit_q, hit_d;
  logic [rbd_pkg::DATA_W-1:0] rdata_q;

  // memory access
  logic                       wr_en, rd_en;
  logic [rbd_pkg::PTR_W-1:0]  waddr, raddr;
  logic [rbd_pkg::DATA_W-1:0] mem [rbd_pkg::DEPTH];

  // pointer neighbors
  logic [rbd_pkg::PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec, idx_addr;
  logic                      full, empty, out_of_range;

  assign head_inc = (head_q == PtrLast) ? '0 : head_q + PtrOne;
  assign head_dec = (head_q == '0) ? PtrLast : head_q - PtrOne;
  assign tail_inc = (tail_q == PtrLast) ? '0 : tail_q + PtrOne;
  assign tail_dec = (tail_q == '0) ? PtrLast : tail_q - PtrOne;
  // depth is a power of two, so the sum wraps in the pointer width
  assign idx_addr = head_q + pos_q;

  assign full         = (fill_q == CntFull);
  assign empty        = (fill_q == '0);
  assign out_of_range = ({1'b0, pos_q} >= fill_q);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  // operation decode
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    status_d = rbd_pkg::STAT_OK;
    hit_d    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    waddr    = tail_q;
    raddr    = head_q;
    case (kind_q)
      rbd_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = rbd_pkg::STAT_FULL;
        end else begin
          wr_en  = 1'b1;
          waddr  = head_dec;
          head_d = head_dec;
          fill_d = fill_q + CntOne;
        end
      end
      rbd_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status_d = rbd_pkg::STAT_FULL;
        end else begin
          wr_en  = 1'b1;
          waddr  = tail_q;
          tail_d = tail_inc;
          fill_d = fill_q + CntOne;
        end
      end
      rbd_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          status_d = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en  = 1'b1;
          hit_d  = 1'b1;
          raddr  = head_q;
          head_d = head_inc;
          fill_d = fill_q - CntOne;
        end
      end
      rbd_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status_d = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en  = 1'b1;
          hit_d  = 1'b1;
          raddr  = tail_dec;
          tail_d = tail_dec;
          fill_d = fill_q - CntOne;
        end
      end
      rbd_pkg::KIND_PEEK_BACK: begin
        if (empty) begin
          status_d = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en = 1'b1;
          hit_d = 1'b1;
          raddr = tail_dec;
        end
      end
      rbd_pkg::KIND_READ_INDEX: begin
        if (out_of_range) begin
          status_d = rbd_pkg::STAT_RANGE;
        end else begin
          rd_en = 1'b1;
          hit_d = 1'b1;
          raddr = idx_addr;
        end
      end
      default: begin
      end
    endcase
  end

  // pointer and count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // result status
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  // slot memory, one write or one registered read per operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[waddr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // result ports, meaningful while respond is up
  assign data_o   = (cmd_i.respond && hit_q) ? rdata_q : '0;
  assign status_o = status_q;
  assign count_o  = fill_q;

endmodule
